FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check on every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Types, codes and helpers shared by the cache directory model.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

  localparam int AddrW  = 32;
  localparam int CntW   = 32;
  localparam int CfgW   = 5;
  localparam int CfgIdxW = 2;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;
  localparam logic [1:0] FUNC_IGNORE = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [2:0] SET_BITS_RST    = 3'd4;
  localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST        = 4'd8;

  typedef struct packed {
    logic [1:0]       func;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]      outcome;
    logic            last;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] evict_total;
  } rsp_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
    sat_inc = (x == '1) ? x : x + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache directory with true LRU replacement and running
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------
//  req     | req_valid / req_stall | func, address
//  rsp     | rsp_valid / rsp_stall | outcome, last, three saturating totals
//  cfg     | cfg_we                | cfg_index, cfg_data
//
//  A load or store passes the s1 register, then the output register; one
//  such item is taken every cycle while no result stalls. A modify gives two
//  results, the second once the first is taken, and holds the item behind it.
//  Tags, ranks and valid bits share a per-set RAM with registered read; the
//  row written by the previous item is forwarded. After reset a clearing
//  pass writes one set per cycle (all 2**MAX_SET_BITS sets, 64 by default)
//  and holds req_stall. A stalled result holds the item behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [salc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [salc_pkg::CfgW-1:0]       cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire salc_pkg::req_t                  req_word,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output salc_pkg::rsp_t                       rsp_word
);
  import salc_pkg::*;

  `include "assert_macros.svh"

  localparam int Sets  = 1 << MAX_SET_BITS;
  localparam int SetW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WayW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RankW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RowW  = MAX_WAYS * (AddrW + RankW + 1);
  localparam logic [RankW-1:0] RankMax = RankW'(MAX_WAYS - 1);
  localparam logic [SetW-1:0]  LastSet = SetW'(Sets - 1);

  typedef logic [MAX_WAYS-1:0][AddrW-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][RankW-1:0] rank_row_t;

  // configuration
  logic [2:0] set_bits;
  logic [4:0] offset_bits;
  logic [3:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RST;
      offset_bits <= OFFSET_BITS_RST;
      ways_in_use <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_bits    <= cfg_data[2:0];
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [2:0]          sb;
  logic [3:0]          ew;
  logic [MAX_WAYS-1:0] way_en;

  always_comb begin
    sb = (32'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
    if (ways_in_use == 4'd0) begin
      ew = 4'd1;
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ew = 4'(MAX_WAYS);
    end else begin
      ew = ways_in_use;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_en[i] = 32'(i) < 32'(ew);
    end
  end

  // address split
  logic [63:0]      addr_ext;
  logic [63:0]      set_full;
  logic [63:0]      tag_full;
  logic [SetW-1:0]  acc_set;
  logic [AddrW-1:0] acc_tag;

  always_comb begin
    addr_ext = {32'd0, req_word.address};
    set_full = (addr_ext >> offset_bits) & ((64'd1 << sb) - 64'd1);
    tag_full = addr_ext >> (6'(offset_bits) + 6'(sb));
    acc_set  = set_full[SetW-1:0];
    acc_tag  = tag_full[AddrW-1:0];
  end

  // clearing pass after reset
  logic            clearing;
  logic [SetW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LastSet) begin
        clearing <= 1'b0;
      end
    end
  end

  // handshake control
  logic s1_valid;
  logic s1_mod;
  logic [SetW-1:0]  s1_set;
  logic [AddrW-1:0] s1_tag;
  logic pend;
  logic out_take;
  logic out_free;
  logic s1_move;
  logic accept;

  assign out_take  = rsp_valid && !rsp_stall;
  assign out_free  = !rsp_valid || (out_take && !pend);
  assign s1_move   = s1_valid && out_free;
  assign req_stall = clearing || (s1_valid && !s1_move);
  assign accept    = req_valid && !req_stall;

  // tag, rank and valid store
  logic [RowW-1:0]     ram_rdata;
  logic [RowW-1:0]     ram_wdata;
  logic [RowW-1:0]     ram_wr;
  logic [SetW-1:0]     ram_waddr;
  logic                ram_we;
  tag_row_t            tag_rd;
  rank_row_t           rank_rd;
  logic [MAX_WAYS-1:0] vld_rd;
  tag_row_t            fwd_tag;
  rank_row_t           fwd_rank;
  logic [MAX_WAYS-1:0] fwd_vld;
  logic                fwd_sel;

  assign ram_we    = clearing || s1_move;
  assign ram_waddr = clearing ? clr_idx : s1_set;
  assign ram_wr    = clearing ? '0 : ram_wdata;

  salc_ram #(
    .WIDTH (RowW),
    .DEPTH (Sets)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wr),
    .re    (accept),
    .raddr (acc_set),
    .rdata (ram_rdata)
  );

  assign {tag_rd, rank_rd, vld_rd} = ram_rdata;

  // lookup and update
  tag_row_t            tag_cur;
  rank_row_t           rank_cur;
  logic [MAX_WAYS-1:0] vrow;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic [MAX_WAYS-1:0] vic_vec;
  logic [WayW-1:0]     hit_w;
  logic [WayW-1:0]     free_w;
  logic [WayW-1:0]     vic_w;
  logic [WayW-1:0]     sel_w;
  logic [1:0]          outcome;
  logic                age_all;
  tag_row_t            tag_new;
  rank_row_t           rank_new;
  logic [MAX_WAYS-1:0] vrow_new;

  function automatic logic [WayW-1:0] first_way(input logic [MAX_WAYS-1:0] v);
    first_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (v[i]) begin
        first_way = WayW'(i);
      end
    end
  endfunction

  always_comb begin
    tag_cur  = fwd_sel ? fwd_tag : tag_rd;
    rank_cur = fwd_sel ? fwd_rank : rank_rd;
    vrow     = fwd_sel ? fwd_vld : vld_rd;
    for (int i = 0; i < MAX_WAYS; i++) begin
      hit_vec[i]  = way_en[i] && vrow[i] && (tag_cur[i] == s1_tag);
      free_vec[i] = way_en[i] && !vrow[i];
      vic_vec[i]  = way_en[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j != i && way_en[j]) begin
          if (j < i) begin
            vic_vec[i] = vic_vec[i] && (rank_cur[i] > rank_cur[j]);
          end else begin
            vic_vec[i] = vic_vec[i] && (rank_cur[i] >= rank_cur[j]);
          end
        end
      end
    end
    hit_w  = first_way(hit_vec);
    free_w = first_way(free_vec);
    vic_w  = first_way(vic_vec);
    if (|hit_vec) begin
      sel_w   = hit_w;
      outcome = OUT_HIT;
      age_all = 1'b0;
    end else if (|free_vec) begin
      sel_w   = free_w;
      outcome = OUT_FILL;
      age_all = 1'b1;
    end else begin
      sel_w   = vic_w;
      outcome = OUT_EVICT;
      age_all = 1'b1;
    end
    tag_new  = tag_cur;
    rank_new = rank_cur;
    vrow_new = vrow;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WayW'(i) == sel_w) begin
        rank_new[i] = '0;
        if (outcome != OUT_HIT) begin
          tag_new[i]  = s1_tag;
          vrow_new[i] = 1'b1;
        end
      end else if (way_en[i] && vrow[i] && rank_cur[i] != RankMax
                   && (age_all || rank_cur[i] < rank_cur[sel_w])) begin
        rank_new[i] = rank_cur[i] + 1'b1;
      end
    end
    ram_wdata = {tag_new, rank_new, vrow_new};
  end

  // totals
  logic [CntW-1:0] hit_cnt;
  logic [CntW-1:0] miss_cnt;
  logic [CntW-1:0] evict_cnt;
  logic [CntW-1:0] hit_next;
  logic [CntW-1:0] miss_next;
  logic [CntW-1:0] evict_next;

  always_comb begin
    hit_next   = (outcome == OUT_HIT) ? sat_inc(hit_cnt) : hit_cnt;
    miss_next  = (outcome == OUT_HIT) ? miss_cnt : sat_inc(miss_cnt);
    evict_next = (outcome == OUT_EVICT) ? sat_inc(evict_cnt) : evict_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      fwd_sel   <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else begin
      if (accept) begin
        s1_valid <= (req_word.func != FUNC_IGNORE);
        s1_mod   <= (req_word.func == FUNC_MODIFY);
        s1_set   <= acc_set;
        s1_tag   <= acc_tag;
        fwd_sel  <= s1_move && (acc_set == s1_set);
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        fwd_vld              <= vrow_new;
        fwd_tag              <= tag_new;
        fwd_rank             <= rank_new;
        hit_cnt              <= hit_next;
        miss_cnt             <= miss_next;
        evict_cnt            <= evict_next;
        rsp_valid            <= 1'b1;
        pend                 <= s1_mod;
        rsp_word.outcome     <= outcome;
        rsp_word.last        <= !s1_mod;
        rsp_word.hit_total   <= hit_next;
        rsp_word.miss_total  <= miss_next;
        rsp_word.evict_total <= evict_next;
      end else if (out_take && pend) begin
        hit_cnt            <= sat_inc(hit_cnt);
        pend               <= 1'b0;
        rsp_word.outcome   <= OUT_HIT;
        rsp_word.last      <= 1'b1;
        rsp_word.hit_total <= sat_inc(hit_cnt);
      end else if (out_take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_pend_shown, !pend || rsp_valid || rst, "second result pending with no output")
  `ASSERT_CLK(a_no_move_pend, s1_move |-> !pend, "access committed ahead of pending result")
  `ASSERT_CLK(a_first_pends, (rsp_valid && !rsp_word.last) |-> pend, "first result without second")
  `ASSERT_CLK(a_evict_le_miss, evict_cnt <= miss_cnt, "evictions exceed misses")
  `ASSERT_CLK(a_no_take_clear, clearing |-> !accept, "word taken during clearing pass")

endmodule

`default_nettype wire

FILE: hw/rtl/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim
// Self-checking bench for the LRU cache directory. A short table of accesses
// (typed outcomes where obvious) runs after reset, then random accesses run
// over a series of register settings. Every result word is checked, field by
// field, against an in-bench LRU directory, with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_set_assoc_lru_cache_sim;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int NSETB        = 6;
  localparam int NWAYS        = 8;
  localparam int NLINES       = (1 << NSETB) * NWAYS;
  localparam int NPHASES      = 11;
  localparam int PHASE_WORDS  = 160;
  localparam int NDIR         = 20;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [1:0] OUT_PREDICT = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [1:0]  outc;
  } dir_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic   req_valid = 1'b0;
  logic   req_stall;
  req_t   req_word = '0;
  logic   rsp_valid;
  logic   rsp_stall = 1'b0;
  rsp_t   rsp_word;

  set_assoc_lru_cache_sim dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always #5 clk = ~clk;

  // directory copy
  logic        line_ok   [NLINES];
  logic [31:0] line_tag  [NLINES];
  logic [2:0]  line_rank [NLINES];
  logic [31:0] hit_tot, miss_tot, evict_tot;
  logic [2:0]  reg_set_bits    = SET_BITS_RST;
  logic [4:0]  reg_offset_bits = OFFSET_BITS_RST;
  logic [3:0]  reg_ways        = WAYS_RST;

  rsp_t pending_rsp [$];

  int err_count     = 0;
  int words_sent    = 0;
  int rsp_checked   = 0;
  int seen_hits     = 0;
  int seen_fills    = 0;
  int seen_evicts   = 0;
  int cycle_count   = 0;
  bit send_burst    = 1'b0;
  bit recv_burst    = 1'b0;

  dir_row_t dir_rows [NDIR] = '{
    '{FUNC_LOAD,   32'h0000_0000, OUT_FILL},
    '{FUNC_LOAD,   32'h0000_000F, OUT_HIT},
    '{FUNC_MODIFY, 32'h0000_0010, OUT_FILL},
    '{FUNC_STORE,  32'hFFFF_FFFF, OUT_FILL},
    '{FUNC_IGNORE, 32'hFFFF_FFFF, OUT_PREDICT},
    '{FUNC_IGNORE, 32'h0000_0000, OUT_PREDICT},
    '{FUNC_LOAD,   32'h0000_0100, OUT_FILL},
    '{FUNC_LOAD,   32'h0000_0200, OUT_FILL},
    '{FUNC_STORE,  32'h0000_0300, OUT_FILL},
    '{FUNC_LOAD,   32'h0000_0400, OUT_FILL},
    '{FUNC_STORE,  32'h0000_0500, OUT_FILL},
    '{FUNC_LOAD,   32'h0000_0600, OUT_FILL},
    '{FUNC_LOAD,   32'h0000_0700, OUT_FILL},
    '{FUNC_LOAD,   32'h0000_0800, OUT_EVICT},
    '{FUNC_LOAD,   32'h0000_0000, OUT_EVICT},
    '{FUNC_STORE,  32'h0000_0100, OUT_PREDICT},
    '{FUNC_MODIFY, 32'hFFFF_FFF0, OUT_HIT},
    '{FUNC_LOAD,   32'hAAAA_AAAA, OUT_PREDICT},
    '{FUNC_STORE,  32'h5555_5555, OUT_PREDICT},
    '{FUNC_MODIFY, 32'h8000_0000, OUT_PREDICT}
  };

  // set_bits, offset_bits, ways_in_use per phase; phase 0 keeps reset values
  int phase_sb [NPHASES] = '{4, 0, 6, 7, 0, 2, 6, 1, 5, 0, 4};
  int phase_ob [NPHASES] = '{4, 0, 16, 31, 16, 3, 0, 31, 2, 0, 4};
  int phase_wy [NPHASES] = '{8, 1, 8, 15, 0, 4, 3, 2, 7, 0, 8};

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  function automatic int eff_set_bits();
    return (reg_set_bits > NSETB) ? NSETB : int'(reg_set_bits);
  endfunction

  function automatic int eff_ways();
    if (reg_ways == 4'd0) return 1;
    if (reg_ways > NWAYS) return NWAYS;
    return int'(reg_ways);
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] x);
    return (x == '1) ? x : x + 32'd1;
  endfunction

  function automatic void age_set(input int base, input int ways, input int way,
                                  input int limit);
    for (int i = 0; i < ways; i++) begin
      if (i != way && line_ok[base+i] && int'(line_rank[base+i]) < limit &&
          int'(line_rank[base+i]) < NWAYS - 1)
        line_rank[base+i] = line_rank[base+i] + 3'd1;
    end
    line_rank[base+way] = '0;
  endfunction

  function automatic logic [1:0] lookup_line(input logic [31:0] addr);
    int sb, ob, ways, base, victim;
    logic [63:0] wide;
    logic [31:0] tag;
    sb   = eff_set_bits();
    ob   = int'(reg_offset_bits);
    ways = eff_ways();
    wide = {32'd0, addr};
    base = int'((wide >> ob) & ((64'd1 << sb) - 64'd1)) * NWAYS;
    tag  = 32'(wide >> (ob + sb));
    for (int i = 0; i < ways; i++) begin
      if (line_ok[base+i] && line_tag[base+i] == tag) begin
        hit_tot = bump(hit_tot);
        age_set(base, ways, i, int'(line_rank[base+i]));
        return OUT_HIT;
      end
    end
    miss_tot = bump(miss_tot);
    for (int i = 0; i < ways; i++) begin
      if (!line_ok[base+i]) begin
        line_ok[base+i]  = 1'b1;
        line_tag[base+i] = tag;
        age_set(base, ways, i, NWAYS);
        return OUT_FILL;
      end
    end
    evict_tot = bump(evict_tot);
    victim = 0;
    for (int i = 1; i < ways; i++)
      if (line_rank[base+i] > line_rank[base+victim]) victim = i;
    line_tag[base+victim] = tag;
    age_set(base, ways, victim, NWAYS);
    return OUT_EVICT;
  endfunction

  function automatic void push_access(input logic [31:0] addr, input logic is_last);
    rsp_t r;
    r.outcome     = lookup_line(addr);
    r.last        = is_last;
    r.hit_total   = hit_tot;
    r.miss_total  = miss_tot;
    r.evict_total = evict_tot;
    pending_rsp.push_back(r);
  endfunction

  function automatic void predict_word(input req_t w);
    case (w.func)
      FUNC_LOAD, FUNC_STORE: begin
        push_access(w.address, 1'b1);
      end
      FUNC_MODIFY: begin
        push_access(w.address, 1'b0);
        push_access(w.address, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic req_t make_word();
    req_t w;
    int sb, ob, pick, set_idx, hot;
    logic [63:0] wide;
    logic [31:0] tag;
    sb   = eff_set_bits();
    ob   = int'(reg_offset_bits);
    pick = $urandom_range(0, 99);
    if (pick < 10) w.func = FUNC_IGNORE;
    else w.func = 2'($urandom_range(0, 2));
    if (pick >= 75) begin
      w.address = $urandom;
    end else begin
      if ($urandom_range(0, 7) == 0) tag = $urandom;
      else tag = 32'($urandom_range(0, eff_ways() + 2));
      hot = (sb >= 2) ? 3 : (1 << sb) - 1;
      if ($urandom_range(0, 3) == 0) set_idx = $urandom_range(0, (1 << sb) - 1);
      else set_idx = $urandom_range(0, hot);
      wide = ({32'd0, tag} << (ob + sb)) | (64'(set_idx) << ob) |
             ({32'd0, 32'($urandom)} & ((64'd1 << ob) - 64'd1));
      w.address = wide[31:0];
    end
    return w;
  endfunction

  task automatic send_word(input req_t w, input logic [1:0] outc);
    int gap, base;
    bit taken;
    if (words_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do begin
      @(negedge clk);
      taken = (req_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    words_sent++;
    base = pending_rsp.size();
    predict_word(w);
    if (outc != OUT_PREDICT && pending_rsp.size() > base)
      pending_rsp[base].outcome = outc;
  endtask

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(posedge clk);
    // an ignored word may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SET_BITS:    reg_set_bits    = data[2:0];
      REG_OFFSET_BITS: reg_offset_bits = data[4:0];
      REG_WAYS_IN_USE: reg_ways        = data[3:0];
      default: begin
      end
    endcase
  endtask

  // result side: draw a hold-off, then take one word
  initial begin : result_side
    int gap, n;
    bit got;
    n = 0;
    forever begin
      if (n % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      n++;
      gap = recv_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        got = (rsp_valid === 1'b1) && !rst;
        @(posedge clk);
      end while (!got);
    end
  end

  always @(negedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with nothing pending, outcome", 32'(rsp_word.outcome), '0);
      end else begin
        want = pending_rsp.pop_front();
        rsp_checked++;
        case (rsp_word.outcome)
          OUT_HIT:   seen_hits++;
          OUT_FILL:  seen_fills++;
          OUT_EVICT: seen_evicts++;
          default: begin
          end
        endcase
        if (rsp_word.outcome !== want.outcome)
          report_mismatch("outcome", 32'(rsp_word.outcome), 32'(want.outcome));
        if (rsp_word.last !== want.last)
          report_mismatch("last", 32'(rsp_word.last), 32'(want.last));
        if (rsp_word.hit_total !== want.hit_total)
          report_mismatch("hit_total", rsp_word.hit_total, want.hit_total);
        if (rsp_word.miss_total !== want.miss_total)
          report_mismatch("miss_total", rsp_word.miss_total, want.miss_total);
        if (rsp_word.evict_total !== want.evict_total)
          report_mismatch("evict_total", rsp_word.evict_total, want.evict_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_rsp.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    req_t w;
    for (int i = 0; i < NLINES; i++) begin
      line_ok[i]   = 1'b0;
      line_tag[i]  = '0;
      line_rank[i] = '0;
    end
    hit_tot   = '0;
    miss_tot  = '0;
    evict_tot = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NDIR; r++) begin
      w.func    = dir_rows[r].func;
      w.address = dir_rows[r].addr;
      send_word(w, dir_rows[r].outc);
    end

    for (int p = 0; p < NPHASES; p++) begin
      if (p > 0) begin
        req_valid <= 1'b0;
        drain_results();
        if (p == 9) begin
          write_reg(REG_SET_BITS,    CfgW'($urandom_range(0, 7)));
          write_reg(REG_OFFSET_BITS, CfgW'($urandom_range(0, 31)));
          write_reg(REG_WAYS_IN_USE, CfgW'($urandom_range(0, 15)));
        end else begin
          write_reg(REG_SET_BITS,    CfgW'(phase_sb[p]));
          write_reg(REG_OFFSET_BITS, CfgW'(phase_ob[p]));
          write_reg(REG_WAYS_IN_USE, CfgW'(phase_wy[p]));
        end
        cfg_we <= 1'b0;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        w = make_word();
        send_word(w, OUT_PREDICT);
        sent++;
      end
    end

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words over %0d register settings; checked %0d results", words_sent,
             NPHASES, rsp_checked);
    $display("outcomes seen: %0d hits, %0d fills, %0d evictions; %0d mismatches", seen_hits,
             seen_fills, seen_evicts, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
